### rtl/core/crc_rec_pkg.sv
// Shared constants and helpers for the fixed-record CRC codec.
// Holds the record layout, register indexes and the byte-wide CRC-32 update.
// No dependencies.
`default_nettype none

package crc_rec_pkg;

   localparam int RecordBytesDefault = 12;

   // Record layout, byte positions
   localparam int PosVersion = 4;
   localparam int PosPhase   = 5;
   localparam int PosCrc     = 8;
   localparam int PosPad     = 12;

   localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
   localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
   localparam logic [7:0]  RecVersion = 8'd1;
   localparam logic [7:0]  Magic [4]  = '{8'h58, 8'h46, 8'h52, 8'h31};

   // Input action codes
   localparam logic ActDecode = 1'b0;
   localparam logic ActEncode = 1'b1;

   // Configuration register indexes
   localparam logic CsrPhaseFirst = 1'b0;
   localparam logic CsrPhaseLast  = 1'b1;

   // Reflected CRC-32, one byte per call (eight bit-steps unrolled)
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // Byte sel of the finished (inverted) CRC, little-endian
   function automatic logic [7:0] crc_out_byte(input logic [31:0] crc, input logic [1:0] sel);
      logic [31:0] fin;
      fin = ~crc;
      return fin[{sel, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

### rtl/core/crc_framed_record_codec_core.sv
// Fixed-length record codec: decoder with running CRC check, byte-serial encoder.
// Depends on crc_rec_pkg (layout constants, CRC-32 byte update).
// Usage:
//  - req channel: one transfer per item. tuser = action (decode byte / encode phase),
//    tdata = data_byte then phase_in, tlast = end_of_record for decode bytes.
//  - rsp channel: result items. tuser = is_verdict, tdata = out_byte, ok, phase_out,
//    tlast = final result caused by one input item.
//  - csr port: write-only phase_first (index 0) and phase_last (index 1), written idle.
// Path: an item is held in the input register, and its first result is then loaded
//  into the result register.
// Throughput: one decode byte per cycle, back to back, while no verdict waits; the
//  byte-wide CRC update sits between the input register and the CRC state. An encode
//  holds the input register until its last record byte, one record byte per cycle while
//  results are taken, CRC built up as bytes go out; a rejected phase is one final result.
// Stalls: while the result register is full and not taken, verdicts and encode bytes
//  wait; plain decode bytes carry on, and the input register still takes one transfer.
// Reset (synchronous): both channels empty, decoder state cleared, bounds back to 1..3.
`default_nettype none

module crc_framed_record_codec_core import crc_rec_pkg::*; #(
   parameter int RECORD_BYTES = RecordBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] phase_in
   input  wire logic        req_tuser,   // [0] action
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [8] ok, [16:9] phase_out, pad
   output logic             rsp_tuser,   // [0] is_verdict
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   localparam int CountWidth = $clog2(RECORD_BYTES + 1);
   localparam int IdxWidth   = $clog2(RECORD_BYTES);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(RECORD_BYTES);
   localparam logic [IdxWidth-1:0]   IdxLast   = IdxWidth'(RECORD_BYTES - 1);

   // Configuration
   logic [7:0] phase_first_ff, phase_last_ff;

   // Input register
   logic       in_valid_ff;
   logic       in_action_ff, in_eor_ff;
   logic [7:0] in_byte_ff, in_phase_ff;

   // Decoder state
   logic [CountWidth-1:0] dec_count_ff, dec_count_in;
   logic [31:0]           dec_crc_ff, dec_crc_in;
   logic                  dec_match_ff, dec_match_in;
   logic [7:0]            dec_phase_ff, dec_phase_in;
   logic                  dec_overrun_ff, dec_overrun_in;

   // Encoder state
   logic [IdxWidth-1:0] enc_idx_ff, enc_idx_in;
   logic [31:0]         enc_crc_ff, enc_crc_in;

   // Result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_verdict_ff, rsp_verdict_in;
   logic       rsp_ok_ff, rsp_ok_in;
   logic [7:0] rsp_phase_ff, rsp_phase_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free, out_load, in_take, enc_phase_ok, dec_good;
   logic [7:0] enc_byte;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_first_ff <= 8'd1;
         phase_last_ff  <= 8'd3;
      end else if (csr_we) begin
         unique case (csr_addr)
            CsrPhaseFirst: phase_first_ff <= csr_wdata;
            CsrPhaseLast:  phase_last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input stage
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_eor_ff    <= req_tlast;
         in_byte_ff   <= req_tdata[7:0];
         in_phase_ff  <= req_tdata[15:8];
      end
   end

   assign enc_phase_ok = (in_phase_ff >= phase_first_ff) && (in_phase_ff <= phase_last_ff);

   // Encoder record byte at the current emit position
   always_comb begin
      enc_byte = 8'h00;
      if (enc_idx_ff < IdxWidth'(PosVersion)) begin
         enc_byte = Magic[enc_idx_ff[1:0]];
      end else if (enc_idx_ff == IdxWidth'(PosVersion)) begin
         enc_byte = RecVersion;
      end else if (enc_idx_ff == IdxWidth'(PosPhase)) begin
         enc_byte = in_phase_ff;
      end else if (enc_idx_ff >= IdxWidth'(PosCrc) && enc_idx_ff < IdxWidth'(PosPad)) begin
         enc_byte = crc_out_byte(enc_crc_ff, enc_idx_ff[1:0]);
      end
   end

   // ---------------------------------------------------------------- processing
   always_comb begin
      dec_count_in   = dec_count_ff;
      dec_crc_in     = dec_crc_ff;
      dec_match_in   = dec_match_ff;
      dec_phase_in   = dec_phase_ff;
      dec_overrun_in = dec_overrun_ff;
      enc_idx_in     = enc_idx_ff;
      enc_crc_in     = enc_crc_ff;
      in_take        = 1'b0;
      out_load       = 1'b0;
      dec_good       = 1'b0;
      rsp_byte_in    = 8'h00;
      rsp_verdict_in = 1'b0;
      rsp_ok_in      = 1'b0;
      rsp_phase_in   = 8'h00;
      rsp_last_in    = 1'b0;

      if (in_valid_ff) begin
         if (in_action_ff == ActDecode) begin
            if (!in_eor_ff || out_free) begin
               in_take = 1'b1;
               if (dec_count_ff < CountFull) begin
                  if (dec_count_ff < CountWidth'(PosVersion)) begin
                     if (in_byte_ff != Magic[dec_count_ff[1:0]]) dec_match_in = 1'b0;
                  end else if (dec_count_ff == CountWidth'(PosVersion)) begin
                     if (in_byte_ff != RecVersion) dec_match_in = 1'b0;
                  end else if (dec_count_ff == CountWidth'(PosPhase)) begin
                     dec_phase_in = in_byte_ff;
                  end else if (dec_count_ff < CountWidth'(PosCrc)) begin
                     if (in_byte_ff != 8'h00) dec_match_in = 1'b0;
                  end else if (dec_count_ff < CountWidth'(PosPad)) begin
                     if (in_byte_ff != crc_out_byte(dec_crc_ff, dec_count_ff[1:0]))
                        dec_match_in = 1'b0;
                  end
                  if (dec_count_ff < CountWidth'(PosCrc))
                     dec_crc_in = crc_byte(dec_crc_ff, in_byte_ff);
                  dec_count_in = dec_count_ff + 1'b1;
               end else begin
                  dec_overrun_in = 1'b1;
               end
               if (in_eor_ff) begin
                  dec_good = !dec_overrun_in && (dec_count_in == CountFull) && dec_match_in
                             && (dec_phase_in >= phase_first_ff)
                             && (dec_phase_in <= phase_last_ff);
                  out_load       = 1'b1;
                  rsp_verdict_in = 1'b1;
                  rsp_ok_in      = dec_good;
                  rsp_phase_in   = dec_good ? dec_phase_in : 8'h00;
                  rsp_last_in    = 1'b1;
                  // verdict given: decoder back to its reset values
                  dec_count_in   = '0;
                  dec_crc_in     = CrcInit;
                  dec_match_in   = 1'b1;
                  dec_phase_in   = 8'h00;
                  dec_overrun_in = 1'b0;
               end
            end
         end else if (out_free) begin
            out_load = 1'b1;
            if (!enc_phase_ok) begin
               in_take     = 1'b1;
               rsp_last_in = 1'b1;
            end else begin
               rsp_byte_in = enc_byte;
               rsp_ok_in   = 1'b1;
               if (enc_idx_ff < IdxWidth'(PosCrc))
                  enc_crc_in = crc_byte(enc_crc_ff, enc_byte);
               if (enc_idx_ff == IdxLast) begin
                  in_take     = 1'b1;
                  rsp_last_in = 1'b1;
                  enc_idx_in  = '0;
                  enc_crc_in  = CrcInit;
               end else begin
                  enc_idx_in = enc_idx_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_count_ff   <= '0;
         dec_crc_ff     <= CrcInit;
         dec_match_ff   <= 1'b1;
         dec_phase_ff   <= 8'h00;
         dec_overrun_ff <= 1'b0;
         enc_idx_ff     <= '0;
         enc_crc_ff     <= CrcInit;
      end else begin
         dec_count_ff   <= dec_count_in;
         dec_crc_ff     <= dec_crc_in;
         dec_match_ff   <= dec_match_in;
         dec_phase_ff   <= dec_phase_in;
         dec_overrun_ff <= dec_overrun_in;
         enc_idx_ff     <= enc_idx_in;
         enc_crc_ff     <= enc_crc_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_byte_ff    <= rsp_byte_in;
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_ok_ff      <= rsp_ok_in;
         rsp_phase_ff   <= rsp_phase_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'h00, rsp_phase_ff, rsp_ok_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // A record in mid-emission keeps its encode item in the input register
   a_enc_holds_item: assert property (@(posedge clock) disable iff (reset)
      (enc_idx_ff != '0) |-> (in_valid_ff && in_action_ff == ActEncode))
      else $error("encoder busy without an encode item");

   // After a verdict the decoder starts a fresh record
   a_dec_cleared: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(out_load && rsp_verdict_in))
         |-> (dec_count_ff == '0 && dec_match_ff && !dec_overrun_ff && dec_crc_ff == CrcInit))
      else $error("decoder state not cleared after verdict");

   // Verdicts carry no record byte
   a_verdict_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_verdict_ff) |-> (rsp_byte_ff == 8'h00))
      else $error("verdict with non-zero byte");

   // A failing encode is a single, final result
   a_enc_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_verdict_ff && !rsp_ok_ff) |-> rsp_last_ff)
      else $error("failing encode result not marked last");
`endif

endmodule

`default_nettype wire
